// ----- rtl/core/mrpt_pkg.sv -----
// ============================================================================
// Miller-Rabin prime test package
// Shared types, witness table and command/status bundles for the controller
// and the datapath of the prime test unit.
// ============================================================================
package mrpt_pkg;

   localparam int IDX_W      = 4;
   localparam int BASE_W     = 6;

   typedef enum logic [1:0] {
      MUL_RB = 2'd0,
      MUL_BB = 2'd1,
      MUL_RR = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        factor_shift;
      logic        round_init;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        write_r;
      logic        write_b;
      logic        exp_shift;
      logic        sq_init;
      logic        sq_inc;
      logic        idx_inc;
   } dp_cmd_type;

   typedef struct packed {
      logic n_is_two;
      logic n_trivial;
      logic q_odd;
      logic exp_zero;
      logic exp_lsb;
      logic bases_done;
      logic mul_done;
      logic r_is_one;
      logic r_is_nm1;
      logic sq_done;
   } dp_status_type;

   function automatic logic [BASE_W-1:0] base_of(input logic [IDX_W-1:0] idx);
      logic [BASE_W-1:0] b;
      unique case (idx)
         4'd0:    b = 6'd2;
         4'd1:    b = 6'd3;
         4'd2:    b = 6'd5;
         4'd3:    b = 6'd7;
         4'd4:    b = 6'd11;
         4'd5:    b = 6'd13;
         4'd6:    b = 6'd17;
         4'd7:    b = 6'd19;
         4'd8:    b = 6'd23;
         4'd9:    b = 6'd29;
         4'd10:   b = 6'd31;
         4'd11:   b = 6'd37;
         default: b = 6'd0;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/core/mrpt_modmul.sv -----
// ============================================================================
// Modular multiplier
// Bit-serial shift-and-add unit computing (x * y) mod m, one multiplier bit
// per cycle, for operands already reduced below the modulus.
// ============================================================================
module mrpt_modmul #(
   parameter int NUM_BITS = 63
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] x,
   input  logic [NUM_BITS-1:0] y,
   input  logic [NUM_BITS-1:0] m,
   output logic                done,
   output logic [NUM_BITS-1:0] product
);

   logic                busy_ff;
   logic                busy_in;
   logic [NUM_BITS-1:0] acc_ff;
   logic [NUM_BITS-1:0] acc_in;
   logic [NUM_BITS-1:0] x_ff;
   logic [NUM_BITS-1:0] x_in;
   logic [NUM_BITS-1:0] y_ff;
   logic [NUM_BITS-1:0] y_in;
   logic [NUM_BITS-1:0] m_ff;
   logic [NUM_BITS-1:0] m_in;
   logic [NUM_BITS:0]   sum;
   logic [NUM_BITS:0]   dbl;
   logic [NUM_BITS-1:0] acc_step;
   logic [NUM_BITS-1:0] x_step;

   assign done    = busy_ff && (y_ff == '0);
   assign product = acc_ff;

   always_comb begin
      sum = {1'b0, acc_ff} + {1'b0, x_ff};
      dbl = {x_ff, 1'b0};
      if (sum >= {1'b0, m_ff}) begin
         acc_step = NUM_BITS'(sum - {1'b0, m_ff});
      end else begin
         acc_step = sum[NUM_BITS-1:0];
      end
      if (dbl >= {1'b0, m_ff}) begin
         x_step = NUM_BITS'(dbl - {1'b0, m_ff});
      end else begin
         x_step = dbl[NUM_BITS-1:0];
      end

      busy_in = busy_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      priority if (start) begin
         busy_in = 1'b1;
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         m_in    = m;
      end else if (busy_ff && (y_ff != '0)) begin
         if (y_ff[0]) begin
            acc_in = acc_step;
         end
         x_in = x_step;
         y_in = y_ff >> 1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   // The running sum and the doubled operand stay reduced during a product.
   a_acc_reduced: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (acc_ff < m_ff))
      else $error("modmul accumulator not reduced");

   a_x_reduced: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (x_ff < m_ff))
      else $error("modmul shifted operand not reduced");

   // A finished product releases the unit unless a new one starts.
   a_done_release: assert property (@(posedge clock) disable iff (reset)
      (done && !start) |=> !busy_ff)
      else $error("modmul stayed busy after a finished product");

endmodule

// ----- rtl/core/mrpt_datapath.sv -----
// ============================================================================
// Miller-Rabin datapath
// Holds the candidate, its odd part and power of two, the witness index and
// the exponentiation registers, and owns the shared modular multiplier.
// ============================================================================
module mrpt_datapath #(
   parameter int NUM_BITS      = 63,
   parameter int NUM_WITNESSES = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [NUM_BITS-1:0]   req_number,
   input  mrpt_pkg::dp_cmd_type  cmd,
   output mrpt_pkg::dp_status_type status
);
   import mrpt_pkg::*;

   localparam int K_W = $clog2(NUM_BITS);

   logic [NUM_BITS-1:0] n_ff;
   logic [NUM_BITS-1:0] n_in;
   logic [NUM_BITS-1:0] q_ff;
   logic [NUM_BITS-1:0] q_in;
   logic [K_W-1:0]      k_ff;
   logic [K_W-1:0]      k_in;
   logic [K_W-1:0]      j_ff;
   logic [K_W-1:0]      j_in;
   logic [IDX_W-1:0]    idx_ff;
   logic [IDX_W-1:0]    idx_in;
   logic [NUM_BITS-1:0] r_ff;
   logic [NUM_BITS-1:0] r_in;
   logic [NUM_BITS-1:0] b_ff;
   logic [NUM_BITS-1:0] b_in;
   logic [NUM_BITS-1:0] e_ff;
   logic [NUM_BITS-1:0] e_in;
   logic [NUM_BITS-1:0] mul_x;
   logic [NUM_BITS-1:0] mul_y;
   logic [NUM_BITS-1:0] mul_product;
   logic                mul_done;
   logic [NUM_BITS-1:0] base_wide;

   assign base_wide = NUM_BITS'(base_of(idx_ff));

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_RB: begin
            mul_x = r_ff;
            mul_y = b_ff;
         end
         MUL_BB: begin
            mul_x = b_ff;
            mul_y = b_ff;
         end
         MUL_RR: begin
            mul_x = r_ff;
            mul_y = r_ff;
         end
         default: begin
            mul_x = r_ff;
            mul_y = r_ff;
         end
      endcase
   end

   mrpt_modmul #(
      .NUM_BITS (NUM_BITS)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .m       (n_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   always_comb begin
      n_in   = n_ff;
      q_in   = q_ff;
      k_in   = k_ff;
      j_in   = j_ff;
      idx_in = idx_ff;
      r_in   = r_ff;
      b_in   = b_ff;
      e_in   = e_ff;
      if (cmd.load) begin
         n_in   = req_number;
         q_in   = req_number - NUM_BITS'(1);
         k_in   = '0;
         idx_in = '0;
      end
      if (cmd.factor_shift) begin
         q_in = q_ff >> 1;
         k_in = k_ff + K_W'(1);
      end
      if (cmd.round_init) begin
         r_in = NUM_BITS'(1);
         b_in = base_wide;
         e_in = q_ff;
      end
      if (cmd.write_r) begin
         r_in = mul_product;
      end
      if (cmd.write_b) begin
         b_in = mul_product;
      end
      if (cmd.exp_shift) begin
         e_in = e_ff >> 1;
      end
      if (cmd.sq_init) begin
         j_in = K_W'(1);
      end
      if (cmd.sq_inc) begin
         j_in = j_ff + K_W'(1);
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      q_ff   <= q_in;
      k_ff   <= k_in;
      j_ff   <= j_in;
      idx_ff <= idx_in;
      r_ff   <= r_in;
      b_ff   <= b_in;
      e_ff   <= e_in;
   end

   always_comb begin
      status.n_is_two   = (n_ff == NUM_BITS'(2));
      status.n_trivial  = (n_ff < NUM_BITS'(2)) || !n_ff[0];
      status.q_odd      = q_ff[0];
      status.exp_zero   = (e_ff == '0);
      status.exp_lsb    = e_ff[0];
      status.bases_done = (idx_ff >= IDX_W'(NUM_WITNESSES)) || (base_wide >= n_ff);
      status.mul_done   = mul_done;
      status.r_is_one   = (r_ff == NUM_BITS'(1));
      status.r_is_nm1   = (r_ff == (n_ff - NUM_BITS'(1)));
      status.sq_done    = (j_ff >= k_ff);
   end

endmodule

// ----- rtl/core/mrpt_ctrl.sv -----
// ============================================================================
// Miller-Rabin controller
// Sequences classification, factoring of n-1, the witness rounds and the
// squaring chain, and holds the result register of the response channel.
// ============================================================================
module mrpt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_prime,
   output mrpt_pkg::dp_cmd_type    cmd,
   input  mrpt_pkg::dp_status_type status
);
   import mrpt_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b000000000001,
      ST_CLASSIFY  = 12'b000000000010,
      ST_FACTOR    = 12'b000000000100,
      ST_BASE_SEL  = 12'b000000001000,
      ST_POW_CHECK = 12'b000000010000,
      ST_WAIT_R    = 12'b000000100000,
      ST_WAIT_B    = 12'b000001000000,
      ST_CHECK_T   = 12'b000010000000,
      ST_SQ_CHECK  = 12'b000100000000,
      ST_WAIT_T    = 12'b001000000000,
      ST_SQ_TEST   = 12'b010000000000,
      ST_FINISH    = 12'b100000000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      verdict_ff;
   logic      verdict_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_prime_ff;
   logic      rsp_prime_in;
   logic      accept;
   logic      out_free;

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_RB;
      state_in     = state_ff;
      verdict_in   = verdict_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_prime_in = rsp_prime_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            priority if (status.n_is_two) begin
               verdict_in = 1'b1;
               state_in   = ST_FINISH;
            end else if (status.n_trivial) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_FACTOR;
            end
         end
         ST_FACTOR: begin
            if (status.q_odd) begin
               state_in = ST_BASE_SEL;
            end else begin
               cmd.factor_shift = 1'b1;
            end
         end
         ST_BASE_SEL: begin
            if (status.bases_done) begin
               verdict_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.round_init = 1'b1;
               state_in       = ST_POW_CHECK;
            end
         end
         ST_POW_CHECK: begin
            priority if (status.exp_zero) begin
               state_in = ST_CHECK_T;
            end else if (status.exp_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MUL_RB;
               state_in      = ST_WAIT_R;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MUL_BB;
               state_in      = ST_WAIT_B;
            end
         end
         ST_WAIT_R: begin
            if (status.mul_done) begin
               cmd.write_r   = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MUL_BB;
               state_in      = ST_WAIT_B;
            end
         end
         ST_WAIT_B: begin
            if (status.mul_done) begin
               cmd.write_b   = 1'b1;
               cmd.exp_shift = 1'b1;
               state_in      = ST_POW_CHECK;
            end
         end
         ST_CHECK_T: begin
            if (status.r_is_one || status.r_is_nm1) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_BASE_SEL;
            end else begin
               cmd.sq_init = 1'b1;
               state_in    = ST_SQ_CHECK;
            end
         end
         ST_SQ_CHECK: begin
            if (status.sq_done) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MUL_RR;
               state_in      = ST_WAIT_T;
            end
         end
         ST_WAIT_T: begin
            if (status.mul_done) begin
               cmd.write_r = 1'b1;
               cmd.sq_inc  = 1'b1;
               state_in    = ST_SQ_TEST;
            end
         end
         ST_SQ_TEST: begin
            priority if (status.r_is_one) begin
               verdict_in = 1'b0;
               state_in   = ST_FINISH;
            end else if (status.r_is_nm1) begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_BASE_SEL;
            end else begin
               state_in = ST_SQ_CHECK;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = verdict_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff   <= verdict_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   // Every accepted transaction starts with classification of the candidate.
   a_accept_classify: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CLASSIFY))
      else $error("accepted transaction did not enter classification");

   // A finished verdict reaches the response register once it is free.
   a_finish_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_FINISH) && out_free) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished verdict was not presented");

   // The multiplier is only started from a state that waits for it next.
   a_mul_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> ((state_ff == ST_WAIT_R) || (state_ff == ST_WAIT_B)
                         || (state_ff == ST_WAIT_T)))
      else $error("multiplier started without a waiting state");

endmodule

// ----- rtl/core/miller_rabin_prime_test_unit.sv -----
// ============================================================================
// Miller-Rabin prime test unit
// Deterministic strong-pseudoprime test over the fixed witnesses 2 to 37,
// built from a sequencing controller and a datapath with one bit-serial
// modular multiplier.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   req_number[NUM_BITS-1:0]
//   rsp       out        rsp_valid/rsp_stall   rsp_is_prime
//
// One transaction is processed at a time; a new one is taken while the
// previous verdict still waits in the response register.
// Each modular product runs bit-serially through the shared multiplier.
// A witness round needs at most 2*(NUM_BITS-1) products including the squarings.
// Even values, zero, one and two are decided in classification, with no products.
// Reset is synchronous and clears the sequencer and the response valid.
// ============================================================================
module miller_rabin_prime_test_unit #(
   parameter int NUM_BITS      = 63,
   parameter int NUM_WITNESSES = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [NUM_BITS-1:0] req_number,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_is_prime
);
   import mrpt_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mrpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_is_prime (rsp_is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   mrpt_datapath #(
      .NUM_BITS      (NUM_BITS),
      .NUM_WITNESSES (NUM_WITNESSES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_number (req_number),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ----- dv/miller_rabin_prime_test_unit_tb.sv -----
// ============================================================================
// Miller-Rabin prime test unit testbench
// Sends candidate integers to the prime test unit and checks each verdict
// against a scoreboard that predicts primality with its own deterministic
// strong-pseudoprime test. A directed set of corner values and known strong
// pseudoprimes comes first. Random candidates follow, mostly of modest width
// so that the run stays short. Random idle bursts occur on both channels, and
// one long hold on the response side fills the unit and stalls its input.
// ============================================================================
module miller_rabin_prime_test_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_BITS      = 63;
   localparam int NUM_WITNESSES = 12;
   localparam int HOLD_CYCLES   = 8000;
   localparam int DRAIN_CYCLES  = 50;
   localparam int CORNER_COUNT  = 23;

   localparam logic [NUM_BITS-1:0] CORNER_NUMBERS [CORNER_COUNT] = '{
      63'd0, 63'd1, 63'd2, 63'd3, 63'd4, 63'd5, 63'd9, 63'd25, 63'd37, 63'd41,
      63'd2047, 63'd1373653, 63'd25326001, 63'd3215031751, 63'd2152302898747,
      63'd3474749660383, 63'd341550071728321, 63'd3825123056546413051,
      63'h7FFF_FFFF_FFFF_FFE7, 63'h7FFF_FFFF_FFFF_FFFF, 63'h4000_0000_0000_0000,
      63'h3FFF_FFFF_FFFF_FFC7, 63'h7FFF_FFFF_FFFF_FFFE
   };

   typedef struct {
      logic [NUM_BITS-1:0] number;
      bit                  verdict;
   } verdict_entry_type;

   class primality_board_type;
      verdict_entry_type verdict_q[$];
      int                mismatches;
      bit [5:0]          witnesses[12] = '{6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13,
                                           6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37};

      function bit [63:0] mulmod(bit [63:0] x, bit [63:0] y, bit [63:0] m);
         bit [63:0] acc;
         acc = 0;
         x = x % m;
         y = y % m;
         while (y != 0) begin
            if (y[0]) begin
               acc = acc + x;
               if (acc >= m) acc = acc - m;
            end
            y = y >> 1;
            x = x << 1;
            if (x >= m) x = x - m;
         end
         return acc;
      endfunction

      function bit [63:0] powmod(bit [63:0] b, bit [63:0] e, bit [63:0] m);
         bit [63:0] r;
         r = 64'd1 % m;
         b = b % m;
         while (e != 0) begin
            if (e[0]) r = mulmod(r, b, m);
            b = mulmod(b, b, m);
            e = e >> 1;
         end
         return r;
      endfunction

      function bit witness_rejects(bit [63:0] w, int k, bit [63:0] q, bit [63:0] n);
         bit [63:0] t;
         t = powmod(w, q, n);
         if (t == 1 || t == n - 1) return 1'b0;
         for (int i = 1; i < k; i++) begin
            t = mulmod(t, t, n);
            if (t == 1) return 1'b1;
            if (t == n - 1) return 1'b0;
         end
         return 1'b1;
      endfunction

      function bit predict_prime(logic [NUM_BITS-1:0] number);
         bit [63:0] n;
         bit [63:0] q;
         int        k;
         n = {1'b0, number};
         if (n == 2) return 1'b1;
         if (n < 2 || !n[0]) return 1'b0;
         q = n - 1;
         k = 0;
         while (!q[0]) begin
            q = q >> 1;
            k++;
         end
         for (int i = 0; i < NUM_WITNESSES && i < 12; i++) begin
            if (64'(witnesses[i]) >= n) break;
            if (witness_rejects(64'(witnesses[i]), k, q, n)) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_request(logic [NUM_BITS-1:0] number);
         verdict_entry_type e;
         e.number  = number;
         e.verdict = predict_prime(number);
         verdict_q = {verdict_q, e};
      endfunction

      function void check_response(logic is_prime);
         verdict_entry_type e;
         if (verdict_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] verdict %b arrived with no transaction outstanding",
                        $realtime, is_prime);
            return;
         end
         e = verdict_q.pop_front();
         if (is_prime !== e.verdict) begin
            mismatches++;
            if (mismatches <= 10)
               $display("[%0t] number %0d: expected is_prime %b, got %b",
                        $realtime, e.number, e.verdict, is_prime);
         end
      endfunction

      function int pending();
         return verdict_q.size();
      endfunction
   endclass

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_stall;
   logic [NUM_BITS-1:0] req_number   = '0;
   logic                rsp_valid;
   logic                rsp_stall    = 1'b0;
   logic                rsp_is_prime;

   primality_board_type board = new();
   bit                  tx_idling;
   bit                  rx_idling;
   bit                  hold_request;

   miller_rabin_prime_test_unit #(
      .NUM_BITS     (NUM_BITS),
      .NUM_WITNESSES(NUM_WITNESSES)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_number  (req_number),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_is_prime(rsp_is_prime)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.note_request(req_number);
         if (rsp_valid && !rsp_stall) board.check_response(rsp_is_prime);
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if (rx_idling && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic offer_number(input logic [NUM_BITS-1:0] number);
      req_valid  <= 1'b1;
      req_number <= number;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (tx_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic offer_random_number();
      logic [63:0] value;
      int          width;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) width = $urandom_range(2, 12);
      else if (pick < 90) width = $urandom_range(13, 24);
      else width = $urandom_range(25, NUM_BITS);
      value = {$urandom, $urandom} & ((64'd1 << width) - 64'd1);
      if ($urandom_range(0, 99) < 85) value[0] = 1'b1;
      offer_number(value[NUM_BITS-1:0]);
   endtask

   task automatic wait_for_verdicts();
      while (board.pending() != 0) @(posedge clock);
   endtask

   initial begin
      tx_idling    = 1'b1;
      rx_idling    = 1'b1;
      hold_request = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (CORNER_NUMBERS[i]) offer_number(CORNER_NUMBERS[i]);

      req_valid <= 1'b0;
      wait_for_verdicts();
      @(negedge clock);

      tx_idling    = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 8; i++) offer_number(63'($urandom_range(0, 200)));
      tx_idling = 1'b1;

      for (int i = 0; i < 50; i++) offer_random_number();

      tx_idling = 1'b0;
      rx_idling = 1'b0;
      for (int i = 0; i < 20; i++) offer_random_number();
      req_valid <= 1'b0;

      wait_for_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("miller_rabin_prime_test_unit regression: pass");
      end else begin
         $display("miller_rabin_prime_test_unit regression: fail");
      end
      $finish;
   end

   initial begin
      #600_000_000;
      $display("miller_rabin_prime_test_unit regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/mrpt_pkg.sv
rtl/core/mrpt_modmul.sv
rtl/core/mrpt_datapath.sv
rtl/core/mrpt_ctrl.sv
rtl/core/miller_rabin_prime_test_unit.sv
dv/miller_rabin_prime_test_unit_tb.sv
